[rtl/tmm_pkg.sv]
// Shared types, register codes and constants for the three-mic echo mixer.
// Used by tmm_cfg, tmm_ctrl, tmm_dp, the top level and the checker.
// No dependencies.
package tmm_pkg;

    // Echo ring geometry
    localparam int DELAY_DEPTH = 2048;
    localparam int DELAY_AW    = $clog2(DELAY_DEPTH);
    localparam int DELAY_CW    = DELAY_AW + 1;

    // DC tracker: reset level is mid-scale, ceiling is full scale, Q12.16
    localparam logic [27:0] OFFSET_RESET = 28'h8000000;
    localparam logic [27:0] OFFSET_MAX   = 28'hFFF0000;

    // Floor division by three: bias makes the value non-negative,
    // then multiply by ceil(2^27 / 3) and keep the bits from 27 up.
    localparam logic [25:0] DIV3_BIAS  = 26'd50331648;
    localparam logic [25:0] DIV3_RECIP = 26'd44739243;

    // Sample saturation level, Q16.8
    localparam int SAMPLE_MAX = 8388352;

    typedef struct packed {
        logic [11:0] mic_one;
        logic [11:0] mic_two;
        logic [11:0] mic_three;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  dac_code;
        logic [11:0] mixed_level;
        logic [11:0] smoothed_level;
    } t_out_item;

    typedef enum logic [2:0] {
        CFG_DC_TRACK_RATE = 3'd0,
        CFG_MIX_GAIN      = 3'd1,
        CFG_FB_GAIN       = 3'd2,
        CFG_WET_GAIN      = 3'd3,
        CFG_CLIP_MAG      = 3'd4,
        CFG_SMOOTH_RATE   = 3'd5,
        CFG_DAC_SCALE     = 3'd6,
        CFG_DELAY_LENGTH  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]         dc_track_rate;
        logic [15:0]         mix_gain;
        logic [15:0]         fb_gain;
        logic [15:0]         wet_gain;
        logic [14:0]         clip_mag;
        logic [15:0]         smooth_rate;
        logic [15:0]         dac_scale;
        logic [DELAY_CW-1:0] ring_len;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TRK1_MUL,
        ST_TRK1_UPD,
        ST_TRK2_MUL,
        ST_TRK2_UPD,
        ST_TRK3_MUL,
        ST_TRK3_UPD,
        ST_SUM3,
        ST_GAIN_MUL,
        ST_GAIN_RND,
        ST_DIV3_MUL,
        ST_DIV3_TAKE,
        ST_MIX_MUL,
        ST_MIX_ADD,
        ST_FB_MUL,
        ST_FB_STORE,
        ST_SMOOTH_MUL,
        ST_SMOOTH_UPD,
        ST_DAC_MUL,
        ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_TRK1_MUL,
        OP_TRK1_UPD,
        OP_TRK2_MUL,
        OP_TRK2_UPD,
        OP_TRK3_MUL,
        OP_TRK3_UPD,
        OP_SUM3,
        OP_GAIN_MUL,
        OP_GAIN_RND,
        OP_DIV3_MUL,
        OP_DIV3_TAKE,
        OP_MIX_MUL,
        OP_MIX_ADD,
        OP_FB_MUL,
        OP_FB_STORE,
        OP_SMOOTH_MUL,
        OP_SMOOTH_UPD,
        OP_DAC_MUL,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

[rtl/tmm_cfg.sv]
// Configuration register bank for the three-mic echo mixer.
// Depends on tmm_pkg (register codes, t_cfg, ring geometry).
module tmm_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output tmm_pkg::t_cfg       o_cfg
);

    logic [15:0] r_dc_track_rate;
    logic [15:0] r_mix_gain;
    logic [15:0] r_fb_gain;
    logic [15:0] r_wet_gain;
    logic [14:0] r_clip_mag;
    logic [15:0] r_smooth_rate;
    logic [15:0] r_dac_scale;
    logic [11:0] r_delay_length;
    logic [tmm_pkg::DELAY_CW-1:0] ring_len;

    // Always able to take a write
    assign o_cfg_ready = 1'b1;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_track_rate <= 16'd131;
            r_mix_gain      <= 16'd19661;
            r_fb_gain       <= 16'd29491;
            r_wet_gain      <= 16'd36045;
            r_clip_mag      <= 15'd1400;
            r_smooth_rate   <= 16'd14418;
            r_dac_scale     <= 16'd5898;
            r_delay_length  <= 12'd1760;
        end else if (i_cfg_valid) begin
            case (tmm_pkg::t_cfg_idx'(i_cfg_index))
                tmm_pkg::CFG_DC_TRACK_RATE: r_dc_track_rate <= i_cfg_data;
                tmm_pkg::CFG_MIX_GAIN:      r_mix_gain      <= i_cfg_data;
                tmm_pkg::CFG_FB_GAIN:       r_fb_gain       <= i_cfg_data;
                tmm_pkg::CFG_WET_GAIN:      r_wet_gain      <= i_cfg_data;
                tmm_pkg::CFG_CLIP_MAG:      r_clip_mag      <= i_cfg_data[14:0];
                tmm_pkg::CFG_SMOOTH_RATE:   r_smooth_rate   <= i_cfg_data;
                tmm_pkg::CFG_DAC_SCALE:     r_dac_scale     <= i_cfg_data;
                tmm_pkg::CFG_DELAY_LENGTH:  r_delay_length  <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // Bound the ring length: zero acts as one, oversize acts as full depth
    always_comb begin
        if (r_delay_length == 12'd0) begin
            ring_len = tmm_pkg::DELAY_CW'(1);
        end else if (32'(r_delay_length) > tmm_pkg::DELAY_DEPTH) begin
            ring_len = tmm_pkg::DELAY_CW'(tmm_pkg::DELAY_DEPTH);
        end else begin
            ring_len = tmm_pkg::DELAY_CW'(r_delay_length);
        end
    end

    assign o_cfg.dc_track_rate = r_dc_track_rate;
    assign o_cfg.mix_gain      = r_mix_gain;
    assign o_cfg.fb_gain       = r_fb_gain;
    assign o_cfg.wet_gain      = r_wet_gain;
    assign o_cfg.clip_mag      = r_clip_mag;
    assign o_cfg.smooth_rate   = r_smooth_rate;
    assign o_cfg.dac_scale     = r_dac_scale;
    assign o_cfg.ring_len      = ring_len;

endmodule

[rtl/tmm_ctrl.sv]
// Sequencer for the three-mic echo mixer: walks one request through the
// shared-multiplier datapath. Depends on tmm_pkg (t_state, t_op, command/status).
module tmm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tmm_pkg::t_dp_status  i_status,
    output tmm_pkg::t_dp_cmd     o_cmd
);

    tmm_pkg::t_state r_state;
    tmm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through the fixed schedule; hold at emit while the output is full
    always_comb begin
        n_state = r_state;
        case (r_state)
            tmm_pkg::ST_IDLE:       if (i_in_valid) n_state = tmm_pkg::ST_TRK1_MUL;
            tmm_pkg::ST_TRK1_MUL:   n_state = tmm_pkg::ST_TRK1_UPD;
            tmm_pkg::ST_TRK1_UPD:   n_state = tmm_pkg::ST_TRK2_MUL;
            tmm_pkg::ST_TRK2_MUL:   n_state = tmm_pkg::ST_TRK2_UPD;
            tmm_pkg::ST_TRK2_UPD:   n_state = tmm_pkg::ST_TRK3_MUL;
            tmm_pkg::ST_TRK3_MUL:   n_state = tmm_pkg::ST_TRK3_UPD;
            tmm_pkg::ST_TRK3_UPD:   n_state = tmm_pkg::ST_SUM3;
            tmm_pkg::ST_SUM3:       n_state = tmm_pkg::ST_GAIN_MUL;
            tmm_pkg::ST_GAIN_MUL:   n_state = tmm_pkg::ST_GAIN_RND;
            tmm_pkg::ST_GAIN_RND:   n_state = tmm_pkg::ST_DIV3_MUL;
            tmm_pkg::ST_DIV3_MUL:   n_state = tmm_pkg::ST_DIV3_TAKE;
            tmm_pkg::ST_DIV3_TAKE:  n_state = tmm_pkg::ST_MIX_MUL;
            tmm_pkg::ST_MIX_MUL:    n_state = tmm_pkg::ST_MIX_ADD;
            tmm_pkg::ST_MIX_ADD:    n_state = tmm_pkg::ST_FB_MUL;
            tmm_pkg::ST_FB_MUL:     n_state = tmm_pkg::ST_FB_STORE;
            tmm_pkg::ST_FB_STORE:   n_state = tmm_pkg::ST_SMOOTH_MUL;
            tmm_pkg::ST_SMOOTH_MUL: n_state = tmm_pkg::ST_SMOOTH_UPD;
            tmm_pkg::ST_SMOOTH_UPD: n_state = tmm_pkg::ST_DAC_MUL;
            tmm_pkg::ST_DAC_MUL:    n_state = tmm_pkg::ST_EMIT;
            tmm_pkg::ST_EMIT:       if (!i_status.out_busy) n_state = tmm_pkg::ST_IDLE;
            default:                n_state = tmm_pkg::ST_IDLE;
        endcase
    end

    // Drive the datapath command for the current step
    always_comb begin
        o_in_stall = (r_state != tmm_pkg::ST_IDLE);
        o_cmd.op   = tmm_pkg::OP_NOP;
        case (r_state)
            tmm_pkg::ST_IDLE:       if (i_in_valid) o_cmd.op = tmm_pkg::OP_LOAD;
            tmm_pkg::ST_TRK1_MUL:   o_cmd.op = tmm_pkg::OP_TRK1_MUL;
            tmm_pkg::ST_TRK1_UPD:   o_cmd.op = tmm_pkg::OP_TRK1_UPD;
            tmm_pkg::ST_TRK2_MUL:   o_cmd.op = tmm_pkg::OP_TRK2_MUL;
            tmm_pkg::ST_TRK2_UPD:   o_cmd.op = tmm_pkg::OP_TRK2_UPD;
            tmm_pkg::ST_TRK3_MUL:   o_cmd.op = tmm_pkg::OP_TRK3_MUL;
            tmm_pkg::ST_TRK3_UPD:   o_cmd.op = tmm_pkg::OP_TRK3_UPD;
            tmm_pkg::ST_SUM3:       o_cmd.op = tmm_pkg::OP_SUM3;
            tmm_pkg::ST_GAIN_MUL:   o_cmd.op = tmm_pkg::OP_GAIN_MUL;
            tmm_pkg::ST_GAIN_RND:   o_cmd.op = tmm_pkg::OP_GAIN_RND;
            tmm_pkg::ST_DIV3_MUL:   o_cmd.op = tmm_pkg::OP_DIV3_MUL;
            tmm_pkg::ST_DIV3_TAKE:  o_cmd.op = tmm_pkg::OP_DIV3_TAKE;
            tmm_pkg::ST_MIX_MUL:    o_cmd.op = tmm_pkg::OP_MIX_MUL;
            tmm_pkg::ST_MIX_ADD:    o_cmd.op = tmm_pkg::OP_MIX_ADD;
            tmm_pkg::ST_FB_MUL:     o_cmd.op = tmm_pkg::OP_FB_MUL;
            tmm_pkg::ST_FB_STORE:   o_cmd.op = tmm_pkg::OP_FB_STORE;
            tmm_pkg::ST_SMOOTH_MUL: o_cmd.op = tmm_pkg::OP_SMOOTH_MUL;
            tmm_pkg::ST_SMOOTH_UPD: o_cmd.op = tmm_pkg::OP_SMOOTH_UPD;
            tmm_pkg::ST_DAC_MUL:    o_cmd.op = tmm_pkg::OP_DAC_MUL;
            tmm_pkg::ST_EMIT:       if (!i_status.out_busy) o_cmd.op = tmm_pkg::OP_EMIT;
            default:                o_cmd.op = tmm_pkg::OP_NOP;
        endcase
    end

endmodule

[rtl/tmm_dp.sv]
// Datapath for the three-mic echo mixer: one shared 27x29 multiplier,
// DC trackers, echo ring memory, smoother and output register.
// Depends on tmm_pkg (types, constants, datapath command codes).
module tmm_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tmm_pkg::t_dp_cmd     i_cmd,
    input  tmm_pkg::t_cfg        i_cfg,
    input  tmm_pkg::t_in_item    i_in_data,
    output tmm_pkg::t_dp_status  o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tmm_pkg::t_out_item   o_out_data
);

    localparam logic signed [25:0] SAT26 = 26'(tmm_pkg::SAMPLE_MAX);
    localparam logic signed [26:0] SAT27 = 27'(tmm_pkg::SAMPLE_MAX);

    // Request and filter state
    logic [11:0]        r_mic1, r_mic2, r_mic3;
    logic [27:0]        r_off1, r_off2, r_off3;
    logic signed [22:0] r_acc;
    logic signed [55:0] r_prod;
    logic [25:0]        r_x;
    logic signed [23:0] r_mixed;
    logic signed [23:0] r_echo;
    logic signed [23:0] r_sv;

    // Echo ring
    logic signed [23:0]               r_mem [tmm_pkg::DELAY_DEPTH];
    logic signed [23:0]               r_rd;
    logic [tmm_pkg::DELAY_AW-1:0]     r_pos;
    logic [tmm_pkg::DELAY_CW-1:0]     r_fill;
    logic [tmm_pkg::DELAY_CW-1:0]     pos_ext;
    logic [tmm_pkg::DELAY_CW-1:0]     pos_inc;

    logic                 r_out_valid;
    tmm_pkg::t_out_item   r_out_data;

    // Combinational terms
    logic signed [28:0] diff1, diff2, diff3;
    logic signed [28:0] s_tmp1, s_tmp2, s_tmp3;
    logic signed [20:0] s1, s2, s3;
    logic signed [23:0] delayed;
    logic [25:0]        mul_a;
    logic signed [28:0] mul_b;
    logic               mul_en;
    logic signed [55:0] mul_p;
    logic signed [55:0] rnd16;
    logic [27:0]        off_cur;
    logic signed [30:0] off_sum;
    logic [27:0]        off_new;
    logic signed [55:0] gain_r;
    logic signed [55:0] gain_q;
    logic [24:0]        div_q;
    logic signed [25:0] mix_sum;
    logic signed [25:0] lim;
    logic signed [25:0] echo_c;
    logic signed [25:0] store_c;
    logic signed [24:0] sv_diff;
    logic signed [26:0] sv_sum;
    logic signed [26:0] sv_c;
    logic signed [55:0] dac_tz;
    logic signed [55:0] dac_sh;
    logic signed [17:0] dac_w;
    logic [7:0]         dac_code;
    logic               out_busy;

    // Truncate toward zero to whole units, re-center at 2048, clamp to 12 bits
    function automatic logic [11:0] to_level(input logic signed [23:0] v);
        logic signed [23:0] tz;
        logic signed [16:0] w;
        begin
            tz = v[23] ? (v + 24'sd255) : v;
            w  = $signed({tz[23], tz[23:8]}) + 17'sd2048;
            if (w < 17'sd0) begin
                to_level = 12'd0;
            end else if (w > 17'sd4095) begin
                to_level = 12'd4095;
            end else begin
                to_level = w[11:0];
            end
        end
    endfunction

    // Mic minus tracked offset, and its rounded Q13.8 form
    assign diff1  = $signed({1'b0, r_mic1, 16'h0000}) - $signed({1'b0, r_off1});
    assign diff2  = $signed({1'b0, r_mic2, 16'h0000}) - $signed({1'b0, r_off2});
    assign diff3  = $signed({1'b0, r_mic3, 16'h0000}) - $signed({1'b0, r_off3});
    assign s_tmp1 = diff1 + 29'sd128;
    assign s_tmp2 = diff2 + 29'sd128;
    assign s_tmp3 = diff3 + 29'sd128;
    assign s1     = $signed(s_tmp1[28:8]);
    assign s2     = $signed(s_tmp2[28:8]);
    assign s3     = $signed(s_tmp3[28:8]);

    // Ring entries beyond the fill mark have never been written and read as zero
    assign pos_ext = {1'b0, r_pos};
    assign pos_inc = pos_ext + 1'b1;
    assign delayed = (pos_ext < r_fill) ? r_rd : 24'sd0;

    // Select multiplier operands for this step
    always_comb begin
        mul_a  = 26'd0;
        mul_b  = 29'sd0;
        mul_en = 1'b0;
        case (i_cmd.op)
            tmm_pkg::OP_TRK1_MUL: begin
                mul_a = {10'd0, i_cfg.dc_track_rate};
                mul_b = diff1;
                mul_en = 1'b1;
            end
            tmm_pkg::OP_TRK2_MUL: begin
                mul_a = {10'd0, i_cfg.dc_track_rate};
                mul_b = diff2;
                mul_en = 1'b1;
            end
            tmm_pkg::OP_TRK3_MUL: begin
                mul_a = {10'd0, i_cfg.dc_track_rate};
                mul_b = diff3;
                mul_en = 1'b1;
            end
            tmm_pkg::OP_GAIN_MUL: begin
                mul_a = {10'd0, i_cfg.mix_gain};
                mul_b = {{6{r_acc[22]}}, r_acc};
                mul_en = 1'b1;
            end
            tmm_pkg::OP_DIV3_MUL: begin
                mul_a = r_x;
                mul_b = {3'b000, tmm_pkg::DIV3_RECIP};
                mul_en = 1'b1;
            end
            tmm_pkg::OP_MIX_MUL: begin
                mul_a = {10'd0, i_cfg.wet_gain};
                mul_b = {{5{delayed[23]}}, delayed};
                mul_en = 1'b1;
            end
            tmm_pkg::OP_FB_MUL: begin
                mul_a = {10'd0, i_cfg.fb_gain};
                mul_b = {{5{delayed[23]}}, delayed};
                mul_en = 1'b1;
            end
            tmm_pkg::OP_SMOOTH_MUL: begin
                mul_a = {10'd0, i_cfg.smooth_rate};
                mul_b = {{4{sv_diff[24]}}, sv_diff};
                mul_en = 1'b1;
            end
            tmm_pkg::OP_DAC_MUL: begin
                mul_a = {10'd0, i_cfg.dac_scale};
                mul_b = {{5{r_sv[23]}}, r_sv};
                mul_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign mul_p = $signed({1'b0, mul_a}) * mul_b;
    assign rnd16 = (r_prod + 56'sd32768) >>> 16;

    // Offset update: add rounded correction, clamp to zero and to full scale
    always_comb begin
        case (i_cmd.op)
            tmm_pkg::OP_TRK2_UPD: off_cur = r_off2;
            tmm_pkg::OP_TRK3_UPD: off_cur = r_off3;
            default:              off_cur = r_off1;
        endcase
        off_sum = $signed({3'b000, off_cur}) + $signed({rnd16[29], rnd16[29:0]});
        if (off_sum[30]) begin
            off_new = 28'd0;
        end else if (off_sum > $signed({3'b000, tmm_pkg::OFFSET_MAX})) begin
            off_new = tmm_pkg::OFFSET_MAX;
        end else begin
            off_new = off_sum[27:0];
        end
    end

    // Gain rounding and floor divide by three
    assign gain_r = r_prod + 56'sd24576;
    assign gain_q = gain_r >>> 14;
    assign div_q  = r_prod[51:27] - 25'd16777216;

    // Echo and store: mixed plus rounded delayed product, then clamp
    assign mix_sum = $signed({{2{r_mixed[23]}}, r_mixed}) + $signed(rnd16[25:0]);
    assign lim     = $signed({3'b000, i_cfg.clip_mag, 8'h00});

    always_comb begin
        if (mix_sum > lim) begin
            echo_c = lim;
        end else if (mix_sum < -lim) begin
            echo_c = -lim;
        end else begin
            echo_c = mix_sum;
        end
        if (mix_sum > SAT26) begin
            store_c = SAT26;
        end else if (mix_sum < -SAT26) begin
            store_c = -SAT26;
        end else begin
            store_c = mix_sum;
        end
    end

    // Smoother step
    assign sv_diff = $signed({r_echo[23], r_echo}) - $signed({r_sv[23], r_sv});
    assign sv_sum  = $signed({{3{r_sv[23]}}, r_sv}) + $signed(rnd16[26:0]);

    always_comb begin
        if (sv_sum > SAT27) begin
            sv_c = SAT27;
        end else if (sv_sum < -SAT27) begin
            sv_c = -SAT27;
        end else begin
            sv_c = sv_sum;
        end
    end

    // DAC code: truncate toward zero, center at 128, clamp to 8 bits
    assign dac_tz = r_prod[55] ? (r_prod + 56'sd16777215) : r_prod;
    assign dac_sh = dac_tz >>> 24;
    assign dac_w  = $signed(dac_sh[17:0]) + 18'sd128;

    always_comb begin
        if (dac_w < 18'sd0) begin
            dac_code = 8'd0;
        end else if (dac_w > 18'sd255) begin
            dac_code = 8'd255;
        end else begin
            dac_code = dac_w[7:0];
        end
    end

    // Hold the product of the last multiply step
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            tmm_pkg::OP_LOAD: begin
                r_mic1 <= i_in_data.mic_one;
                r_mic2 <= i_in_data.mic_two;
                r_mic3 <= i_in_data.mic_three;
            end
            tmm_pkg::OP_TRK2_MUL: r_acc <= {{2{s1[20]}}, s1};
            tmm_pkg::OP_TRK3_MUL: r_acc <= r_acc + {{2{s2[20]}}, s2};
            tmm_pkg::OP_SUM3:     r_acc <= r_acc + {{2{s3[20]}}, s3};
            tmm_pkg::OP_GAIN_RND: r_x <= gain_q[25:0] + tmm_pkg::DIV3_BIAS;
            // Quotient is bounded well inside 24 bits
            tmm_pkg::OP_DIV3_TAKE: r_mixed <= $signed(div_q[23:0]);
            tmm_pkg::OP_MIX_ADD:   r_echo <= echo_c[23:0];
            default: begin
            end
        endcase
    end

    // Filter state: offsets, smoother, ring position and fill mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off1 <= tmm_pkg::OFFSET_RESET;
            r_off2 <= tmm_pkg::OFFSET_RESET;
            r_off3 <= tmm_pkg::OFFSET_RESET;
            r_sv   <= 24'sd0;
            r_pos  <= '0;
            r_fill <= '0;
        end else begin
            case (i_cmd.op)
                tmm_pkg::OP_TRK1_UPD:   r_off1 <= off_new;
                tmm_pkg::OP_TRK2_UPD:   r_off2 <= off_new;
                tmm_pkg::OP_TRK3_UPD:   r_off3 <= off_new;
                tmm_pkg::OP_SMOOTH_UPD: r_sv   <= sv_c[23:0];
                tmm_pkg::OP_FB_STORE: begin
                    if (pos_inc >= i_cfg.ring_len) begin
                        r_pos <= '0;
                    end else begin
                        r_pos <= pos_inc[tmm_pkg::DELAY_AW-1:0];
                    end
                    if (pos_ext >= r_fill) begin
                        r_fill <= pos_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Ring memory: one write port, one registered read at the current position
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tmm_pkg::OP_FB_STORE) begin
            r_mem[r_pos] <= store_c[23:0];
        end
        r_rd <= r_mem[r_pos];
    end

    // Output register
    assign out_busy = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == tmm_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tmm_pkg::OP_EMIT) begin
            r_out_data.dac_code       <= dac_code;
            r_out_data.mixed_level    <= to_level(r_mixed);
            r_out_data.smoothed_level <= to_level(r_sv);
        end
    end

    assign o_status.out_busy = out_busy;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

[rtl/three_mic_mix_feedback_echo.sv]
// One request at a time: a new request is taken only in idle, after the last one emits.
// Each request takes nine products on one shared multiplier, eight of them followed by
// a use step, plus a sum step, the accept step and emit; a stalled output holds emit.
// Reset (synchronous, active low) restores registers, DC offsets to mid-scale,
// smoother and ring position; a fill mark makes unwritten ring entries read zero.
module three_mic_mix_feedback_echo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tmm_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tmm_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    tmm_pkg::t_cfg        cfg;
    tmm_pkg::t_dp_cmd     dp_cmd;
    tmm_pkg::t_dp_status  dp_status;

    // Register bank
    tmm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Sequencer
    tmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Arithmetic and storage
    tmm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_cfg       (cfg),
        .i_in_data   (i_in_data),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[rtl/tmm_chk.sv]
// Port-level checker for three_mic_mix_feedback_echo, attached by bind.
// Depends on tmm_pkg (payload types).
module tmm_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input tmm_pkg::t_in_item   i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tmm_pkg::t_out_item  o_out_data,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [2:0]          i_cfg_index,
    input logic [15:0]         i_cfg_data
);

    // Reset drops any pending result
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result still valid after reset");

    // A taken request makes the block busy on the next cycle
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while one is in flight");

    // A new result only appears at the end of a busy stretch
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in flight");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

endmodule

bind three_mic_mix_feedback_echo tmm_chk u_tmm_chk (.*);
